// File: rtl/sth_pkg.sv
package sth_pkg;

    localparam int NUM_BUCKETS_DEF = 64;
    localparam int COORD_BITS_DEF  = 16;

    localparam int CNT_W      = 48;
    localparam int TRUE_W     = 32;
    localparam int DMP_W      = 17;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // shared multiply/divide unit operand widths
    localparam int MD_A_W = 64;
    localparam int MD_B_W = 48;
    localparam int MD_D_W = 48;
    localparam int MD_P_W = MD_A_W + MD_B_W;

    localparam logic [DMP_W-1:0] ONE_Q16         = 17'h10000;
    localparam int               DOMAIN_HIGH_RST = 65536;
    localparam logic [CNT_W-1:0] INIT_COUNT_RST  = 48'h0000_0001_0000;
    localparam logic [DMP_W-1:0] DAMPING_RST     = 17'h08000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOMAIN_LOW    = 2'd0,
        CFG_DOMAIN_HIGH   = 2'd1,
        CFG_INITIAL_COUNT = 2'd2,
        CFG_DAMPING       = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_UPDATE   = 1'b0,
        OP_ESTIMATE = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_EVAL,
        S_EWAIT,
        S_F1,
        S_G,
        S_CG,
        S_DLT,
        S_EEND,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        U_IDLE,
        U_MUL,
        U_DIV
    } t_md_state;

    typedef struct packed {
        logic              start;
        logic              skip_div;
        logic [MD_A_W-1:0] a;
        logic [MD_B_W-1:0] b;
        logic [MD_D_W-1:0] d;
    } t_md_req;

    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [MD_A_W-1:0] q;
    } t_md_rsp;

endpackage

// File: rtl/sth_if.sv
interface sth_item_if import sth_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  operation;
    logic [COORD_BITS-1:0] range_low;
    logic [COORD_BITS:0]   range_high;
    logic [TRUE_W-1:0]     true_count;

    modport source (output valid, operation, range_low, range_high, true_count, input ready);
    modport sink   (input valid, operation, range_low, range_high, true_count, output ready);
endinterface

interface sth_result_if import sth_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] estimate;
    logic             update_skipped;

    modport source (output valid, estimate, update_skipped, input ready);
    modport sink   (input valid, estimate, update_skipped, output ready);
endinterface

interface sth_cfg_if import sth_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/sth_muldiv.sv
module sth_muldiv import sth_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_md_req i_req,
    output t_md_rsp o_rsp
);

    // floor(a*b/d): shift-add multiply, one multiplier bit a cycle (stops when
    // the remaining multiplier is zero), then restoring divide, one quotient
    // bit a cycle. ovf when the quotient does not fit in MD_A_W bits.
    localparam int CNT_BITS = $clog2(MD_A_W);

    t_md_state           r_state, n_state;
    logic                r_done, n_done;
    logic                r_ovf, n_ovf;
    logic                r_skip, n_skip;
    logic [MD_P_W-1:0]   r_mcand, n_mcand;
    logic [MD_P_W-1:0]   r_prod, n_prod;
    logic [MD_B_W-1:0]   r_mplr, n_mplr;
    logic [MD_D_W-1:0]   r_d, n_d;
    logic [MD_D_W-1:0]   r_rem, n_rem;
    logic [MD_A_W-1:0]   r_lo, n_lo;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [MD_D_W:0]     w_trial;
    logic [MD_D_W:0]     w_diff;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_ovf   = r_ovf;
        n_skip  = r_skip;
        n_mcand = r_mcand;
        n_prod  = r_prod;
        n_mplr  = r_mplr;
        n_d     = r_d;
        n_rem   = r_rem;
        n_lo    = r_lo;
        n_cnt   = r_cnt;
        w_trial = {r_rem, r_lo[MD_A_W-1]};
        w_diff  = w_trial - {1'b0, r_d};
        unique case (r_state)
            U_IDLE: begin
                if (i_req.start) begin
                    n_mcand = MD_P_W'(i_req.a);
                    n_mplr  = i_req.b;
                    n_d     = i_req.d;
                    n_skip  = i_req.skip_div;
                    n_prod  = '0;
                    n_state = U_MUL;
                end
            end
            U_MUL: begin
                if (r_mplr == '0) begin
                    n_lo  = r_prod[MD_A_W-1:0];
                    n_rem = r_prod[MD_P_W-1:MD_A_W];
                    n_cnt = '0;
                    n_ovf = 1'b0;
                    if (r_skip) begin
                        n_done  = 1'b1;
                        n_state = U_IDLE;
                    end else if (r_prod[MD_P_W-1:MD_A_W] >= r_d) begin
                        n_done  = 1'b1;
                        n_ovf   = 1'b1;
                        n_state = U_IDLE;
                    end else begin
                        n_state = U_DIV;
                    end
                end else begin
                    if (r_mplr[0]) begin
                        n_prod = r_prod + r_mcand;
                    end
                    n_mcand = r_mcand << 1;
                    n_mplr  = r_mplr >> 1;
                end
            end
            U_DIV: begin
                // no borrow: trial remainder reaches the divisor
                if (!w_diff[MD_D_W]) begin
                    n_rem = w_diff[MD_D_W-1:0];
                    n_lo  = {r_lo[MD_A_W-2:0], 1'b1};
                end else begin
                    n_rem = w_trial[MD_D_W-1:0];
                    n_lo  = {r_lo[MD_A_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_done  = 1'b1;
                    n_state = U_IDLE;
                end
            end
            default: begin
                n_state = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ovf   <= n_ovf;
        r_skip  <= n_skip;
        r_mcand <= n_mcand;
        r_prod  <= n_prod;
        r_mplr  <= n_mplr;
        r_d     <= n_d;
        r_rem   <= n_rem;
        r_lo    <= n_lo;
        r_cnt   <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_rsp.q    = r_lo;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("muldiv done held for two cycles");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == U_DIV) |-> (r_rem < r_d))
        else $error("muldiv remainder not below divisor");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == U_IDLE))
        else $error("muldiv done while still busy");

endmodule

// File: rtl/sth_engine.sv
module sth_engine import sth_pkg::*; #(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sth_item_if.sink              i_item,
    sth_result_if.source          o_result,
    input  logic [COORD_BITS-1:0] i_domain_low,
    input  logic [COORD_BITS:0]   i_domain_high,
    input  logic [CNT_W-1:0]      i_initial_count,
    input  logic [DMP_W-1:0]      i_damping,
    input  logic                  i_reload
);

    localparam int IDX_W  = $clog2(NUM_BUCKETS);
    localparam int SPAN_W = COORD_BITS + 1;
    // coordinates scaled by NUM_BUCKETS so bucket edges land on integers
    localparam int SC_W   = COORD_BITS + 1 + IDX_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_BUCKETS - 1);

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_upd, n_upd;
    t_op               r_op, n_op;
    logic [SC_W-1:0]   r_rl, n_rl;
    logic [SC_W-1:0]   r_rh, n_rh;
    logic [SC_W-1:0]   r_blo, n_blo;
    logic [SPAN_W-1:0] r_span, n_span;
    logic [SPAN_W-1:0] r_ov, n_ov;
    logic [CNT_W-1:0]  r_truth, n_truth;
    logic [CNT_W-1:0]  r_acc, n_acc;
    logic [CNT_W-1:0]  r_err, n_err;
    logic              r_up, n_up;
    logic              r_skip, n_skip;
    logic              r_ovalid, n_ovalid;
    logic [CNT_W-1:0]  r_oest, n_oest;
    logic              r_oskip, n_oskip;
    logic [CNT_W-1:0]  r_mem [NUM_BUCKETS];
    logic [CNT_W-1:0]  r_rdata;

    logic              w_next;
    logic              w_we;
    logic [CNT_W-1:0]  w_wdata;
    logic [SC_W-1:0]   w_base;
    logic [SC_W-1:0]   w_bhi;
    logic [SC_W-1:0]   w_lo;
    logic [SC_W-1:0]   w_hi;
    logic [SPAN_W-1:0] w_ov;
    logic [CNT_W-1:0]  w_term;
    logic [CNT_W:0]    w_sum;
    logic [CNT_W-1:0]  w_acc_sat;
    logic              w_up;
    logic [CNT_W-1:0]  w_err;
    logic [DMP_W-1:0]  w_dmp;
    logic [DMP_W-1:0]  w_g;
    logic [CNT_W-1:0]  w_delta;
    logic [CNT_W:0]    w_inc;
    logic [CNT_W-1:0]  w_newc;
    t_md_req           w_req;
    t_md_rsp           w_rsp;

    sth_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        w_base = SC_W'(i_domain_low) * SC_W'(NUM_BUCKETS);
        w_bhi  = r_blo + SC_W'(r_span);
        w_lo   = (r_rl > r_blo) ? r_rl : r_blo;
        w_hi   = (r_rh < w_bhi) ? r_rh : w_bhi;
        w_ov   = (w_hi > w_lo) ? SPAN_W'(w_hi - w_lo) : '0;

        w_up   = r_truth >= r_acc;
        w_err  = w_up ? (r_truth - r_acc) : (r_acc - r_truth);
        w_dmp  = (i_damping > ONE_Q16) ? ONE_Q16 : i_damping;
        w_g    = w_rsp.q[FRAC_BITS+DMP_W-1:FRAC_BITS];

        // quotient overflow saturates the correction
        w_delta = w_rsp.ovf ? '1 : w_rsp.q[MD_A_W-1:FRAC_BITS];
        w_inc   = {1'b0, r_rdata} + {1'b0, w_delta};
        if (r_up) begin
            w_newc = w_inc[CNT_W] ? '1 : w_inc[CNT_W-1:0];
        end else begin
            w_newc = (w_delta >= r_rdata) ? '0 : (r_rdata - w_delta);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_upd    = r_upd;
        n_op     = r_op;
        n_rl     = r_rl;
        n_rh     = r_rh;
        n_blo    = r_blo;
        n_span   = r_span;
        n_ov     = r_ov;
        n_truth  = r_truth;
        n_acc    = r_acc;
        n_err    = r_err;
        n_up     = r_up;
        n_skip   = r_skip;
        n_ovalid = r_ovalid;
        n_oest   = r_oest;
        n_oskip  = r_oskip;
        w_next   = 1'b0;
        w_we     = 1'b0;
        w_wdata  = i_initial_count;
        w_term   = '0;
        w_req    = '0;

        if (o_result.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                w_we  = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == IDX_LAST) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_item.valid && !i_reload) begin
                    n_op    = t_op'(i_item.operation);
                    n_rl    = SC_W'(i_item.range_low) * SC_W'(NUM_BUCKETS);
                    n_rh    = SC_W'(i_item.range_high) * SC_W'(NUM_BUCKETS);
                    n_truth = {i_item.true_count, FRAC_BITS'(0)};
                    n_span  = (i_domain_high > SPAN_W'(i_domain_low)) ?
                              (i_domain_high - SPAN_W'(i_domain_low)) : '0;
                    n_blo   = w_base;
                    n_idx   = '0;
                    n_upd   = 1'b0;
                    n_acc   = '0;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_ov    = w_ov;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_ov == '0) begin
                    w_next = 1'b1;
                end else if (!r_upd) begin
                    if (r_ov == r_span) begin
                        w_term = r_rdata;
                        n_acc  = w_acc_sat;
                        w_next = 1'b1;
                    end else begin
                        w_req.start = 1'b1;
                        w_req.a     = MD_A_W'(r_rdata);
                        w_req.b     = MD_B_W'(r_ov);
                        w_req.d     = MD_D_W'(r_span);
                        n_state     = S_EWAIT;
                    end
                end else if (r_ov == r_span) begin
                    // fully covered bucket: overlap fraction is exactly one
                    w_req.start    = 1'b1;
                    w_req.skip_div = 1'b1;
                    w_req.a        = MD_A_W'(r_rdata);
                    w_req.b        = MD_B_W'(w_dmp);
                    n_state        = S_CG;
                end else begin
                    w_req.start = 1'b1;
                    w_req.a     = MD_A_W'(r_ov) + MD_A_W'(NUM_BUCKETS);
                    w_req.b     = MD_B_W'(ONE_Q16);
                    w_req.d     = MD_D_W'(r_span) + MD_D_W'(NUM_BUCKETS);
                    n_state     = S_F1;
                end
            end
            S_EWAIT: begin
                if (w_rsp.done) begin
                    w_term = w_rsp.q[CNT_W-1:0];
                    n_acc  = w_acc_sat;
                    w_next = 1'b1;
                end
            end
            S_F1: begin
                if (w_rsp.done) begin
                    w_req.start    = 1'b1;
                    w_req.skip_div = 1'b1;
                    w_req.a        = w_rsp.q;
                    w_req.b        = MD_B_W'(w_dmp);
                    n_state        = S_G;
                end
            end
            S_G: begin
                if (w_rsp.done) begin
                    w_req.start    = 1'b1;
                    w_req.skip_div = 1'b1;
                    w_req.a        = MD_A_W'(r_rdata);
                    w_req.b        = MD_B_W'(w_g);
                    n_state        = S_CG;
                end
            end
            S_CG: begin
                if (w_rsp.done) begin
                    w_req.start = 1'b1;
                    w_req.a     = w_rsp.q;
                    w_req.b     = MD_B_W'(r_err);
                    w_req.d     = MD_D_W'(r_acc);
                    n_state     = S_DLT;
                end
            end
            S_DLT: begin
                if (w_rsp.done) begin
                    w_we    = 1'b1;
                    w_wdata = w_newc;
                    w_next  = 1'b1;
                end
            end
            S_EEND: begin
                n_skip = (r_op == OP_UPDATE) && (r_acc == '0);
                if ((r_op == OP_UPDATE) && (r_acc != '0) && (w_err != '0)) begin
                    n_up    = w_up;
                    n_err   = w_err;
                    n_upd   = 1'b1;
                    n_idx   = '0;
                    n_blo   = w_base;
                    n_state = S_FETCH;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || o_result.ready) begin
                    n_ovalid = 1'b1;
                    n_oest   = r_acc;
                    n_oskip  = r_skip;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_next) begin
            n_blo = r_blo + SC_W'(r_span);
            if (r_idx == IDX_LAST) begin
                n_idx   = '0;
                n_state = r_upd ? S_DONE : S_EEND;
            end else begin
                n_idx   = r_idx + 1'b1;
                n_state = S_FETCH;
            end
        end

        if (i_reload) begin
            n_idx   = '0;
            n_state = S_CLEAR;
        end
    end

    // saturating accumulate of one bucket's share
    always_comb begin
        w_sum     = {1'b0, r_acc} + {1'b0, w_term};
        w_acc_sat = w_sum[CNT_W] ? '1 : w_sum[CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_upd   <= n_upd;
        r_op    <= n_op;
        r_rl    <= n_rl;
        r_rh    <= n_rh;
        r_blo   <= n_blo;
        r_span  <= n_span;
        r_ov    <= n_ov;
        r_truth <= n_truth;
        r_acc   <= n_acc;
        r_err   <= n_err;
        r_up    <= n_up;
        r_skip  <= n_skip;
        r_oest  <= n_oest;
        r_oskip <= n_oskip;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_idx] <= w_wdata;
        end
        r_rdata <= r_mem[r_idx];
    end

    assign i_item.ready            = (r_state == S_IDLE) && !i_reload;
    assign o_result.valid          = r_ovalid;
    assign o_result.estimate       = r_oest;
    assign o_result.update_skipped = r_oskip;

    a_ov_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> (r_ov <= r_span))
        else $error("bucket overlap exceeds bucket width");

    a_upd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && r_upd) |-> (r_err != '0 && r_acc != '0))
        else $error("correction pass with zero error or zero estimate");

    a_est_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DLT && !i_reload) |=> $stable(r_acc))
        else $error("estimate changed during correction pass");

endmodule

// File: rtl/self_tuning_histogram_update_top.sv
// An estimate item sweeps every bucket once, and each partly covered edge bucket (at most
// two) also needs a multiply/divide. An update item with nonzero error and estimate adds
// a second sweep with a correction on every covered bucket. Throughput: one item at a time;
// the next is accepted once the engine is back in idle after the result register loads,
// which waits while a result is still held; the shared unit works one bit per cycle.
// Reset and each initial_count write start a clear of the count memory.
module self_tuning_histogram_update_top import sth_pkg::*; #(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sth_item_if.sink     i_item,
    sth_result_if.source o_result,
    sth_cfg_if.sink      i_cfg
);

    logic [COORD_BITS-1:0] r_domain_low;
    logic [COORD_BITS:0]   r_domain_high;
    logic [CNT_W-1:0]      r_initial_count;
    logic [DMP_W-1:0]      r_damping;
    logic                  w_cfg_we;
    logic                  w_reload;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_we    = i_cfg.valid;
    assign w_reload    = w_cfg_we && (t_cfg_idx'(i_cfg.index) == CFG_INITIAL_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_domain_low    <= '0;
            r_domain_high   <= (COORD_BITS + 1)'(DOMAIN_HIGH_RST);
            r_initial_count <= INIT_COUNT_RST;
            r_damping       <= DAMPING_RST;
        end else if (w_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_DOMAIN_LOW:    r_domain_low    <= i_cfg.data[COORD_BITS-1:0];
                CFG_DOMAIN_HIGH:   r_domain_high   <= i_cfg.data[COORD_BITS:0];
                CFG_INITIAL_COUNT: r_initial_count <= i_cfg.data[CNT_W-1:0];
                CFG_DAMPING:       r_damping       <= i_cfg.data[DMP_W-1:0];
                default:           r_damping       <= r_damping;
            endcase
        end
    end

    sth_engine #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .COORD_BITS  (COORD_BITS)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (i_item),
        .o_result        (o_result),
        .i_domain_low    (r_domain_low),
        .i_domain_high   (r_domain_high),
        .i_initial_count (r_initial_count),
        .i_damping       (r_damping),
        .i_reload        (w_reload)
    );

endmodule

// File: sim/sth_checker.sv
module sth_checker import sth_pkg::*; #(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sth_item_if   item,
    sth_result_if result,
    sth_cfg_if    cfg,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_checked,
    output int    o_skipped
);

    typedef struct packed {
        logic [CNT_W-1:0] estimate;
        logic             update_skipped;
    } t_expect;

    localparam logic [63:0] CNT_MAX = (64'd1 << CNT_W) - 64'd1;

    logic [63:0] dom_lo, dom_hi, init_cnt, damp;
    logic [63:0] counts [NUM_BUCKETS];
    t_expect     expected_q [$];

    // floor(a*b/d), saturated to all ones
    function automatic logic [63:0] scaled_quot(logic [63:0] a, logic [63:0] b,
                                                logic [63:0] d);
        logic [127:0] p;
        logic [127:0] q;
        p = {64'd0, a} * {64'd0, b};
        q = p / {64'd0, d};
        return (q[127:64] != 0) ? '1 : q[63:0];
    endfunction

    function automatic logic [63:0] bucket_cover(logic [63:0] rl, logic [63:0] rh,
                                                 logic [63:0] span, int i);
        logic [63:0] blo, bhi, a, b;
        blo = dom_lo * NUM_BUCKETS + i * span;
        bhi = blo + span;
        a = (rl > blo) ? rl : blo;
        b = (rh < bhi) ? rh : bhi;
        return (b > a) ? b - a : 64'd0;
    endfunction

    function automatic t_expect apply_query(logic op, logic [63:0] rlo, logic [63:0] rhi,
                                            logic [63:0] tc);
        logic [63:0] rl, rh, truth, span, est, err, dmp, ov, f1, g, delta, c;
        logic        up;
        t_expect     r;
        rl = rlo * NUM_BUCKETS;
        rh = rhi * NUM_BUCKETS;
        truth = tc << 16;
        span = (dom_hi > dom_lo) ? dom_hi - dom_lo : 64'd0;
        est = 0;
        r.update_skipped = 1'b0;
        if (span > 0) begin
            for (int i = 0; i < NUM_BUCKETS; i++) begin
                ov = bucket_cover(rl, rh, span, i);
                if (ov > 0) est += scaled_quot(counts[i], ov, span);
            end
        end
        if (est > CNT_MAX) est = CNT_MAX;
        if (op == OP_UPDATE) begin
            if (est == 0) begin
                r.update_skipped = 1'b1;
            end else begin
                up = truth >= est;
                err = up ? truth - est : est - truth;
                dmp = (damp > ONE_Q16) ? 64'(ONE_Q16) : damp;
                for (int i = 0; i < NUM_BUCKETS && err != 0; i++) begin
                    ov = bucket_cover(rl, rh, span, i);
                    c = counts[i];
                    if (ov != 0) begin
                        f1 = ((ov + NUM_BUCKETS) << 16) / (span + NUM_BUCKETS);
                        g = (f1 * dmp) >> 16;
                        delta = scaled_quot(c * g, err, est) >> 16;
                        if (up) c = (delta > CNT_MAX - c) ? CNT_MAX : c + delta;
                        else    c = (delta >= c) ? 64'd0 : c - delta;
                        counts[i] = c;
                    end
                end
            end
        end
        r.estimate = est[CNT_W-1:0];
        return r;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_expect e;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            dom_lo <= 0;
            dom_hi <= DOMAIN_HIGH_RST;
            init_cnt = INIT_COUNT_RST;
            damp <= DAMPING_RST;
            for (int i = 0; i < NUM_BUCKETS; i++) counts[i] = INIT_COUNT_RST;
            expected_q.delete();
            o_fail_count <= 0;
            o_checked <= 0;
            o_skipped <= 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (t_cfg_idx'(cfg.index))
                    CFG_DOMAIN_LOW:  dom_lo <= 64'(cfg.data[15:0]);
                    CFG_DOMAIN_HIGH: dom_hi <= 64'(cfg.data[16:0]);
                    CFG_INITIAL_COUNT: begin
                        init_cnt = 64'(cfg.data[CNT_W-1:0]);
                        for (int i = 0; i < NUM_BUCKETS; i++) counts[i] = init_cnt;
                    end
                    CFG_DAMPING:     damp <= 64'(cfg.data[16:0]);
                endcase
            end
            if (item.valid && item.ready)
                expected_q.insert(expected_q.size(),
                                  apply_query(item.operation, 64'(item.range_low),
                                              64'(item.range_high), 64'(item.true_count)));
            if (result.valid && result.ready) begin
                if (expected_q.size() == 0) begin
                    $error("result item with no expectation: estimate %0d", result.estimate);
                    errs++;
                end else begin
                    e = expected_q.pop_front();
                    o_checked <= o_checked + 1;
                    if (e.update_skipped) o_skipped <= o_skipped + 1;
                    if (e.estimate !== result.estimate) begin
                        $error("estimate: expected %0d, got %0d", e.estimate, result.estimate);
                        errs++;
                    end
                    if (e.update_skipped !== result.update_skipped) begin
                        $error("update_skipped: expected %0d, got %0d",
                               e.update_skipped, result.update_skipped);
                        errs++;
                    end
                end
            end
            if (errs != 0) o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

// File: sim/tb_top.sv
module tb_top;
    import sth_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count, pending, checked, skipped;
    bit   idle_on = 1'b1;
    bit   hold_req = 1'b0;
    int   items_sent = 0;
    logic [63:0] cur_lo = 0, cur_hi = 65536;

    sth_item_if   item_if();
    sth_result_if result_if();
    sth_cfg_if    cfg_if();

    self_tuning_histogram_update_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    sth_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .item         (item_if),
        .result       (result_if),
        .cfg          (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_skipped    (skipped)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #1500000000;
        $display("CHECK FAILED");
        $finish;
    end

    // result receiver: random stalls, one long hold-off on request
    initial begin
        result_if.ready <= 1'b0;
        forever begin
            if (hold_req) begin
                result_if.ready <= 1'b0;
                repeat (1500) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                result_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_item(t_op op, logic [15:0] rl, logic [16:0] rh, logic [31:0] tc);
        item_if.valid      <= 1'b1;
        item_if.operation  <= op;
        item_if.range_low  <= rl;
        item_if.range_high <= rh;
        item_if.true_count <= tc;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        items_sent++;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // leaves valid high; the caller drops it after the last write
    task automatic write_reg(t_cfg_idx idx, logic [47:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            CFG_DOMAIN_LOW:  cur_lo = 64'(value[15:0]);
            CFG_DOMAIN_HIGH: cur_hi = 64'(value[16:0]);
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic set_domain(logic [15:0] lo, logic [16:0] hi, logic [47:0] init,
                              logic [16:0] dmp);
        write_reg(CFG_DOMAIN_LOW, 48'(lo));
        write_reg(CFG_DOMAIN_HIGH, 48'(hi));
        write_reg(CFG_INITIAL_COUNT, init);
        write_reg(CFG_DAMPING, 48'(dmp));
        cfg_if.valid <= 1'b0;
    endtask

    task automatic random_items(int n);
        logic [63:0] span, rl, rh, w;
        logic [31:0] tc;
        t_op         op;
        for (int k = 0; k < n; k++) begin
            op = ($urandom_range(0, 2) == 0) ? OP_ESTIMATE : OP_UPDATE;
            case ($urandom_range(0, 4))
                0:       tc = 0;
                1:       tc = $urandom;
                2:       tc = $urandom >> $urandom_range(8, 28);
                3:       tc = 32'hFFFF_FFFF - $urandom_range(0, 3);
                default: tc = $urandom_range(0, 2000);
            endcase
            span = (cur_hi > cur_lo) ? cur_hi - cur_lo : 64'd1;
            if ($urandom_range(0, 15) == 0) begin
                rl = $urandom_range(0, 65535);
                rh = $urandom_range(0, 65536);
            end else if ($urandom_range(0, 29) == 0) begin
                rl = (cur_lo > 3) ? cur_lo - $urandom_range(0, 3) : 0;
                rh = cur_hi + $urandom_range(0, 3);
            end else begin
                rl = cur_lo + $urandom_range(0, 32'(span - 1));
                w  = $urandom_range(1, (span > 16) ? 32'(span / 16) : 1);
                rh = rl + w;
            end
            if (rl > 65535) rl = 65535;
            if (rh > 65536) rh = 65536;
            send_item(op, rl[15:0], rh[16:0], tc);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        item_if.valid <= 1'b0;
        item_if.operation <= OP_UPDATE;
        item_if.range_low <= '0;
        item_if.range_high <= '0;
        item_if.true_count <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_DOMAIN_LOW;
        cfg_if.data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: whole domain, reversed, outside, edges, extreme counts
        send_item(OP_ESTIMATE, 16'd0, 17'd65536, 32'd0);
        send_item(OP_UPDATE, 16'd0, 17'd65536, 32'd0);
        send_item(OP_ESTIMATE, 16'd0, 17'd65536, 32'd0);
        send_item(OP_UPDATE, 16'd0, 17'd65536, 32'hFFFF_FFFF);
        send_item(OP_UPDATE, 16'd500, 17'd100, 32'd7);
        send_item(OP_ESTIMATE, 16'd700, 17'd700, 32'd7);
        send_item(OP_UPDATE, 16'd65535, 17'd65536, 32'd1);
        send_item(OP_ESTIMATE, 16'hFFFF, 17'h1FFFF, 32'hFFFF_FFFF);
        send_item(OP_UPDATE, 16'd1, 17'd2, 32'd5);
        send_item(OP_UPDATE, 16'd1000, 17'd1500, 32'd100000);
        send_item(OP_UPDATE, 16'd1000, 17'd1500, 32'd0);
        send_item(OP_ESTIMATE, 16'd1000, 17'd1500, 32'd0);
        send_item(OP_UPDATE, 16'h5555, 17'h0AAAA, 32'hAAAA_5555);
        send_item(OP_UPDATE, 16'h2AAA, 17'h15555, 32'h5555_AAAA);
        wait_drained();

        // huge counts over full domain, full damping; receiver holds off once
        set_domain(16'd0, 17'd65536, 48'hFFFF_FFFF_FFFF, 17'd65536);
        hold_req = 1'b1;
        random_items(150);
        wait_drained();

        set_domain(16'd1000, 17'd1064, 48'(64'($urandom) << 8), 17'h1FFFF);
        random_items(150);
        wait_drained();

        set_domain(16'd65535, 17'd65536, 48'h0000_0001_0000, 17'd0);
        random_items(100);
        wait_drained();

        // empty domain and zero counts: every update skipped
        set_domain(16'd500, 17'd100, 48'h0000_0100_0000, 17'd40000);
        random_items(40);
        wait_drained();
        set_domain(16'd0, 17'd1, 48'd0, 17'd65535);
        random_items(40);
        wait_drained();

        for (int p = 0; p < 5; p++) begin
            cur_lo = $urandom_range(0, 60000);
            cur_hi = cur_lo + $urandom_range(1, 32'(65536 - cur_lo));
            set_domain(cur_lo[15:0], cur_hi[16:0],
                       48'({$urandom, $urandom} >> $urandom_range(16, 40)),
                       17'($urandom_range(0, 131071)));
            if (p == 4) idle_on = 1'b0;
            random_items(130);
            wait_drained();
        end

        $display("Sent %0d items over several domain, count and damping settings;", items_sent);
        $display("%0d results compared, %0d updates flagged as skipped.", checked, skipped);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
